[rtl/memory_map_access_checker_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the memory map access checker
// Shared concurrent assertion forms, clocked, one of them reset-qualified.
// ----------------------------------------------------------------------------
`ifndef MEMORY_MAP_ACCESS_CHECKER_MACROS_SVH
`define MEMORY_MAP_ACCESS_CHECKER_MACROS_SVH

// check prop at every edge once out of reset
`define MMAC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check prop at every edge, reset included
`define MMAC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/mmac_pkg.sv]
// ----------------------------------------------------------------------------
// mmac_pkg
// Types, register indexes, operation codes and region kind permissions.
// ----------------------------------------------------------------------------
package mmac_pkg;

  localparam int ADDR_W     = 64;
  localparam int KIND_W     = 3;
  localparam int COUNT_W    = 7;
  localparam int GUARD_W    = 16;
  localparam int INDEX_W    = 6;
  localparam int WIDTH_W    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int MAX_ACCESS_BYTES = 8;

  localparam logic [GUARD_W-1:0] GUARD_RESET = 16'h1000;

  localparam logic [CFG_IDX_W-1:0] REG_REGION_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GUARD_ADDRESS = 2'd1;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_CHECK = 1'b1;

  localparam logic [KIND_W-1:0] KIND_USABLE       = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RESERVED     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ACPI_RECLAIM = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ACPI_NVS     = 3'd3;
  localparam logic [KIND_W-1:0] KIND_BAD          = 3'd4;
  localparam logic [KIND_W-1:0] KIND_BOOT_RECLAIM = 3'd5;
  localparam logic [KIND_W-1:0] KIND_KERNEL       = 3'd6;
  localparam logic [KIND_W-1:0] KIND_FRAMEBUFFER  = 3'd7;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] last;
    logic [KIND_W-1:0] kind;
  } region_entry_t;

  function automatic logic kind_allows(input logic [KIND_W-1:0] kind, input logic wr);
    logic ok;
    if (wr) begin
      ok = kind inside {KIND_USABLE, KIND_ACPI_RECLAIM, KIND_BOOT_RECLAIM, KIND_FRAMEBUFFER};
    end else begin
      ok = kind inside {KIND_USABLE, KIND_ACPI_RECLAIM, KIND_ACPI_NVS, KIND_BOOT_RECLAIM,
                        KIND_KERNEL, KIND_FRAMEBUFFER};
    end
    return ok;
  endfunction

endpackage

[rtl/mmac_ram.sv]
// ----------------------------------------------------------------------------
// mmac_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module mmac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/memory_map_access_checker.sv]
// ----------------------------------------------------------------------------
// memory_map_access_checker
// Checks byte spans against a loaded table of typed memory regions.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): operation 0 loads a region entry,
// operation 1 checks an access span. The result channel (out_valid/out_stall)
// carries one access_allowed bit per check and nothing for a load.
// Configuration (cfg_valid/cfg_ready): index 0 region_count, 1 guard_address.
// A load is written to the region RAM as it is taken. A check refused up front
// (below guard, bad width, wrapping span, empty table) goes through the emit
// state to the output register without a scan. Otherwise each cursor position
// scans the table from entry 0, one entry per cycle through the single read port
// of the region RAM; a span needs at most eight positions. One item is in work at
// a time; in_stall stays high until its result sits in the output register.
// While the receiver stalls, the result holds; the next item may be taken
// meanwhile, and its result waits in the emit state until the output register
// has room. Reset clears the control state and loads region_count 0 and
// guard_address 0x1000; the region table holds no defined contents until loaded.
// ----------------------------------------------------------------------------
`include "memory_map_access_checker_macros.svh"

module memory_map_access_checker
  import mmac_pkg::*;
#(
  parameter int MAX_REGIONS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_operation,
  input  logic [INDEX_W-1:0]    in_entry_index,
  input  logic [ADDR_W-1:0]     in_entry_base,
  input  logic [ADDR_W-1:0]     in_entry_length,
  input  logic [KIND_W-1:0]     in_entry_kind,
  input  logic [ADDR_W-1:0]     in_access_address,
  input  logic [WIDTH_W-1:0]    in_access_width,
  input  logic                  in_is_write,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_access_allowed,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int AW = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CW = $clog2(MAX_REGIONS + 1);
  localparam int EW = $bits(region_entry_t);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic [COUNT_W-1:0] count_r;
  logic [GUARD_W-1:0] guard_r;
  logic [ADDR_W-1:0]  cursor_r, cursor_nxt;
  logic [ADDR_W-1:0]  last_r, last_nxt;
  logic               wr_r, wr_nxt;
  logic [CW-1:0]      n_r, n_nxt;
  logic [CW-1:0]      idx_r, idx_nxt;
  logic [CW-1:0]      eidx_r, eidx_nxt;
  logic               v_r, v_nxt;
  logic               res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_data_r, out_data_nxt;

  logic               in_xfer;
  logic [CW-1:0]      n_sel;
  logic [ADDR_W:0]    span_sum;
  logic               early_fail;
  logic               ram_wr_en;
  logic [AW-1:0]      ram_wr_addr;
  region_entry_t      ram_wr_ent;
  logic               ram_rd_en;
  logic [EW-1:0]      ram_rd_data;
  region_entry_t      ent;
  logic               hit;
  logic               slot_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_access_allowed = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      guard_r <= GUARD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_REGION_COUNT:  count_r <= cfg_data[COUNT_W-1:0];
        REG_GUARD_ADDRESS: guard_r <= cfg_data[GUARD_W-1:0];
        default: ;
      endcase
    end
  end

  assign n_sel = (32'(count_r) > MAX_REGIONS) ? CW'(MAX_REGIONS) : CW'(count_r);
  assign span_sum = {1'b0, in_access_address}
                  + {{(ADDR_W+1-WIDTH_W){1'b0}}, in_access_width} - (ADDR_W+1)'(1);
  assign early_fail = (in_access_address < {{(ADDR_W-GUARD_W){1'b0}}, guard_r})
                   || (in_access_width == '0)
                   || (32'(in_access_width) > MAX_ACCESS_BYTES)
                   || span_sum[ADDR_W]
                   || (n_sel == '0);

  assign ram_wr_en   = in_xfer && (in_operation == OP_LOAD)
                    && (32'(in_entry_index) < MAX_REGIONS);
  assign ram_wr_addr = AW'(in_entry_index);
  assign ram_wr_ent.base = in_entry_base;
  assign ram_wr_ent.last = in_entry_base + in_entry_length - ADDR_W'(1);
  assign ram_wr_ent.kind = in_entry_kind;

  assign ram_rd_en = (state_r == ST_SCAN) && (idx_r < n_r);

  mmac_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_REGIONS)
  ) u_region_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_ent),
    .rd_en   (ram_rd_en),
    .rd_addr (idx_r[AW-1:0]),
    .rd_data (ram_rd_data)
  );

  assign ent       = region_entry_t'(ram_rd_data);
  assign hit       = (cursor_r >= ent.base) && (cursor_r <= ent.last);
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    cursor_nxt    = cursor_r;
    last_nxt      = last_r;
    wr_nxt        = wr_r;
    n_nxt         = n_r;
    idx_nxt       = idx_r;
    eidx_nxt      = eidx_r;
    v_nxt         = 1'b0;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer && (in_operation == OP_CHECK)) begin
          cursor_nxt = in_access_address;
          last_nxt   = span_sum[ADDR_W-1:0];
          wr_nxt     = in_is_write;
          n_nxt      = n_sel;
          idx_nxt    = '0;
          res_nxt    = 1'b0;
          state_nxt  = early_fail ? ST_EMIT : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (ram_rd_en) begin
          idx_nxt  = idx_r + CW'(1);
          eidx_nxt = idx_r;
          v_nxt    = 1'b1;
        end
        if (v_r) begin
          if (hit) begin
            v_nxt   = 1'b0;
            idx_nxt = '0;
            if (!kind_allows(ent.kind, wr_r)) begin
              res_nxt   = 1'b0;
              state_nxt = ST_EMIT;
            end else if (ent.last >= last_r) begin
              res_nxt   = 1'b1;
              state_nxt = ST_EMIT;
            end else begin
              cursor_nxt = ent.last + ADDR_W'(1);
            end
          end else if (eidx_r == n_r - CW'(1)) begin
            v_nxt     = 1'b0;
            res_nxt   = 1'b0;
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      v_r         <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      v_r         <= v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cursor_r   <= cursor_nxt;
    last_r     <= last_nxt;
    wr_r       <= wr_nxt;
    n_r        <= n_nxt;
    idx_r      <= idx_nxt;
    eidx_r     <= eidx_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  `MMAC_ASSERT(a_valid_only_in_scan, clk, rst_n, v_r |-> (state_r == ST_SCAN), "read data valid outside scan")
  `MMAC_ASSERT(a_scan_has_entries, clk, rst_n, (state_r == ST_SCAN) |-> (n_r != '0 && cursor_r <= last_r), "scan with empty table or cursor past span")
  `MMAC_ASSERT(a_eval_in_range, clk, rst_n, v_r |-> (eidx_r < n_r), "evaluated entry beyond region count")
  `MMAC_ASSERT(a_emit_lands, clk, rst_n, (state_r == ST_EMIT && !out_valid_r) |=> (out_valid_r && state_r == ST_IDLE), "result not moved to output register")

endmodule
